@@ rtl/bqrm_pkg.sv @@
// Shared types and constants for the bounded queue with rotate-to-maximum.
`default_nettype none
package bqrm_pkg;

  // Fixed field widths.
  localparam int VALUE_W  = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 5;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ROT = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_ROT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/bqrm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module bqrm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/bqrm_ctrl.sv @@
// Queue controller: pointers, request sequencing, max scan and in-memory rotation.
`default_nettype none
module bqrm_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bqrm_pkg::REQ_W-1:0]    req_type,
  input  wire logic [bqrm_pkg::VALUE_W-1:0]  value,
  input  wire logic [bqrm_pkg::CAP_W-1:0]    capacity,
  output logic                               mem_we,
  output logic [AW-1:0]                      mem_waddr,
  output logic [bqrm_pkg::VALUE_W-1:0]       mem_wdata,
  output logic [AW-1:0]                      mem_raddr,
  input  wire logic [bqrm_pkg::VALUE_W-1:0]  mem_rdata,
  output logic                               done,
  output logic [bqrm_pkg::STATUS_W-1:0]      status,
  output logic [bqrm_pkg::VALUE_W-1:0]       data_out,
  output logic [CW-1:0]                      fill_count
);

  localparam int CMPW = (CW > bqrm_pkg::CAP_W) ? CW : bqrm_pkg::CAP_W;

  // Circular address add; a is below DEPTH and b is at most DEPTH.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  bqrm_pkg::state_t state, state_next;
  logic [AW-1:0]                     head, head_next;
  logic [CW-1:0]                     count, count_next;
  logic [AW-1:0]                     off, off_next;
  logic [AW-1:0]                     best_idx, best_idx_next;
  logic signed [bqrm_pkg::VALUE_W-1:0] best_val, best_val_next;
  logic                              done_next;
  logic [bqrm_pkg::STATUS_W-1:0]     status_next;
  logic [bqrm_pkg::VALUE_W-1:0]      data_out_next;
  logic [CW-1:0]                     fill_count_next;
  logic [AW-1:0]                     tail;
  logic                              is_full;
  logic [AW-1:0]                     cand_idx;
  logic signed [bqrm_pkg::VALUE_W-1:0] cand_val;

  assign busy = (state != bqrm_pkg::S_IDLE);
  assign tail = wrap_add(head, count);
  assign is_full = (CMPW'(count) >= CMPW'(capacity)) || (count >= CW'(DEPTH));

  // Running maximum; the earliest element wins a tie.
  always_comb begin
    if ((off == '0) || ($signed(mem_rdata) > best_val)) begin
      cand_idx = off;
      cand_val = $signed(mem_rdata);
    end else begin
      cand_idx = best_idx;
      cand_val = best_val;
    end
  end

  // State register, pointers and the result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bqrm_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= done_next;
    end
    off        <= off_next;
    best_idx   <= best_idx_next;
    best_val   <= best_val_next;
    status     <= status_next;
    data_out   <= data_out_next;
    fill_count <= fill_count_next;
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    off_next        = off;
    best_idx_next   = best_idx;
    best_val_next   = best_val;
    done_next       = 1'b0;
    status_next     = bqrm_pkg::ST_DONE;
    data_out_next   = '0;
    fill_count_next = count;
    mem_we          = 1'b0;
    mem_waddr       = tail;
    mem_wdata       = value;
    mem_raddr       = head;

    unique case (state)
      bqrm_pkg::S_IDLE: begin
        if (start) begin
          case (req_type)
            bqrm_pkg::REQ_ENQ: begin
              done_next = 1'b1;
              if (is_full) begin
                status_next = bqrm_pkg::ST_FULL;
              end else begin
                mem_we          = 1'b1;
                count_next      = count + CW'(1);
                fill_count_next = count + CW'(1);
              end
            end
            bqrm_pkg::REQ_DEQ: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = bqrm_pkg::ST_EMPTY;
              end else begin
                state_next = bqrm_pkg::S_DEQ;
              end
            end
            bqrm_pkg::REQ_ROT: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = bqrm_pkg::ST_EMPTY;
              end else if (count == CW'(1)) begin
                done_next = 1'b1;
              end else begin
                off_next   = '0;
                state_next = bqrm_pkg::S_SCAN;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // Front element arrives from memory.
      bqrm_pkg::S_DEQ: begin
        data_out_next   = mem_rdata;
        head_next       = wrap_add(head, CW'(1));
        count_next      = count - CW'(1);
        fill_count_next = count - CW'(1);
        done_next       = 1'b1;
        state_next      = bqrm_pkg::S_IDLE;
      end

      // One element per cycle from front to back; read runs one ahead.
      bqrm_pkg::S_SCAN: begin
        best_idx_next = cand_idx;
        best_val_next = cand_val;
        mem_raddr     = wrap_add(head, CW'(off) + CW'(1));
        off_next      = off + AW'(1);
        if (off == AW'(count - CW'(1))) begin
          off_next = '0;
          if (cand_idx == '0) begin
            done_next  = 1'b1;
            state_next = bqrm_pkg::S_IDLE;
          end else begin
            state_next = bqrm_pkg::S_ROT;
          end
        end
      end

      // Move the elements ahead of the maximum behind the tail, then advance head.
      bqrm_pkg::S_ROT: begin
        mem_raddr = wrap_add(head, CW'(off));
        mem_waddr = wrap_add(tail, CW'(off - AW'(1)));
        mem_wdata = mem_rdata;
        mem_we    = (off != '0);
        off_next  = off + AW'(1);
        if (off == best_idx) begin
          head_next  = wrap_add(head, CW'(best_idx));
          done_next  = 1'b1;
          state_next = bqrm_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bqrm_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/bounded_queue_rotate_max_top.sv @@
// Top level of the bounded queue with rotate-to-maximum.
//
// Requests enter on start/req_type/value and are taken at a clock edge with
// start high and busy low. Each request gives exactly one result beat:
// done is high for one cycle with status, data_out and fill_count valid.
// The receiver cannot hold results off.
// Enqueue: the result follows in the cycle after acceptance; busy stays low, so
// a request may follow every cycle. Dequeue: the front element is read in S_DEQ
// and the result is registered from there. Rotate: the held elements are scanned
// one per cycle through the memory's single read port, then the elements ahead
// of the maximum are copied behind the tail one per cycle. Rotate on an empty or
// one-element queue gives its result straight from idle. The capacity register
// is written through cfg_we/cfg_wdata while idle; the user must keep to this, as
// the block leaves it unchecked. Reset clears the head pointer and count, sets
// capacity to 16; the element memory is not cleared and needs no clearing pass.
`default_nettype none
module bounded_queue_rotate_max_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [bqrm_pkg::REQ_W-1:0]            req_type,
  input  wire logic signed [bqrm_pkg::VALUE_W-1:0]   value,
  input  wire logic                                  cfg_we,
  input  wire logic [bqrm_pkg::CAP_W-1:0]            cfg_wdata,
  output logic                                       done,
  output logic [bqrm_pkg::STATUS_W-1:0]              status,
  output logic signed [bqrm_pkg::VALUE_W-1:0]        data_out,
  output logic [$clog2(DEPTH+1)-1:0]                 fill_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [bqrm_pkg::CAP_W-1:0]   capacity;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [bqrm_pkg::VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [bqrm_pkg::VALUE_W-1:0] mem_rdata;
  logic [bqrm_pkg::VALUE_W-1:0] data_raw;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bqrm_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  bqrm_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .value      (value),
    .capacity   (capacity),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .done       (done),
    .status     (status),
    .data_out   (data_raw),
    .fill_count (fill_count)
  );

  assign data_out = $signed(data_raw);

  bqrm_ram #(
    .WIDTH  (bqrm_pkg::VALUE_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
